/* hdl/arms_pkg.sv */
// ----------------------------------------------------------------------------
// arms_pkg
// Shared widths, operation codes and request/response types for the ac rms
// voltage meter and its iterative arithmetic core.
// ----------------------------------------------------------------------------
`default_nettype none

package arms_pkg;

  // converter and counter widths
  localparam int ADC_BITS   = 12;
  localparam int COUNT_BITS = 16;

  // register and result widths
  localparam int SENS_W  = 18;
  localparam int LOOP_W  = 8;
  localparam int MV_W    = 22;
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = (COUNT_BITS > SENS_W) ? COUNT_BITS : SENS_W;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SENS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOOPS = CFG_IDX_W'(2);

  // window sum holds up to 2^COUNT_BITS squares of ADC_BITS differences
  localparam int SUM_W = COUNT_BITS + 2 * ADC_BITS;

  // root of mean << 16 carries 8 fraction bits
  localparam int SQ_FRAC = 16;
  localparam int RAD_W   = 2 * ADC_BITS + SQ_FRAC;
  localparam int ROOT_W  = RAD_W / 2;

  // millivolt scaling: mv = (root * 3300 * sensitivity + 2^27) >> 28
  localparam int SCALE_MV    = 3300;
  localparam int SCALE_W     = 12;
  localparam int K_W         = SENS_W + SCALE_W;
  localparam int SCALE_SHIFT = 28;
  localparam int MUL_W       = ROOT_W + K_W + 1;
  localparam logic [MV_W-1:0] MV_MAX = {MV_W{1'b1}};

  // core shifter and datapath widths
  localparam int B_W0   = (SUM_W > RAD_W) ? SUM_W : RAD_W;
  localparam int B_W    = (B_W0 > TOTAL_W) ? B_W0 : TOTAL_W;
  localparam int CW0    = (B_W + 2 > MUL_W) ? B_W + 2 : MUL_W;
  localparam int CORE_W = (CW0 > SCALE_SHIFT + MV_W + 1) ? CW0 : SCALE_SHIFT + MV_W + 1;
  localparam int STEP_W = $clog2(B_W + 1);

  // reset values
  localparam logic [COUNT_BITS-1:0] SPP_RESET   = COUNT_BITS'(256);
  localparam logic [SENS_W-1:0]     SENS_RESET  = SENS_W'(256);
  localparam logic [LOOP_W-1:0]     LOOPS_RESET = LOOP_W'(5);
  localparam logic [ADC_BITS-1:0]   OFFSET_RESET = ADC_BITS'(1) << (ADC_BITS - 1);

  // core operations
  localparam logic [1:0] OP_MAC  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic              start;
    logic [1:0]        op;
    logic [STEP_W-1:0] steps;
    logic [CORE_W-1:0] w;
    logic [CORE_W-1:0] a;
    logic [B_W-1:0]    b;
  } arms_req_t;

  typedef struct packed {
    logic              done;
    logic [CORE_W-1:0] result;
  } arms_rsp_t;

endpackage

`default_nettype wire

/* hdl/arms_core.sv */
// ----------------------------------------------------------------------------
// arms_core
// Iterative arithmetic core built around one shared add/subtract unit:
// shift-add multiply-accumulate, restoring divide and digit-by-digit
// square root, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arms_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire arms_pkg::arms_req_t req,
  output arms_pkg::arms_rsp_t      rsp
);
  import arms_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [1:0]        op_r;
  logic [CORE_W-1:0] w_r;
  logic [CORE_W-1:0] a_r;
  logic [B_W-1:0]    b_r;

  logic [CORE_W-1:0] rem_div;
  logic [CORE_W-1:0] rem_sqrt;
  logic [CORE_W-1:0] trial;
  logic [CORE_W-1:0] opa;
  logic [CORE_W-1:0] opb;
  logic              sub;
  logic [CORE_W:0]   sum;
  logic              cy;

  // operand selection for the shared adder
  always_comb begin
    rem_div  = {w_r[CORE_W-2:0], b_r[B_W-1]};
    rem_sqrt = {w_r[CORE_W-3:0], b_r[B_W-1 -: 2]};
    trial    = {a_r[CORE_W-3:0], 2'b01};
    unique case (op_r)
      OP_DIV: begin
        opa = rem_div;
        opb = a_r;
        sub = 1'b1;
      end
      OP_SQRT: begin
        opa = rem_sqrt;
        opb = trial;
        sub = 1'b1;
      end
      default: begin
        opa = w_r;
        opb = b_r[0] ? a_r : '0;
        sub = 1'b0;
      end
    endcase
  end

  // shared add/subtract, carry out means no borrow
  assign sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (CORE_W + 1)'(sub);
  assign cy  = sum[CORE_W];

  // sequencing of steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MAC;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      w_r <= req.w;
      a_r <= req.a;
      b_r <= req.b;
    end else if (busy_r) begin
      unique case (op_r)
        OP_DIV: begin
          w_r <= cy ? sum[CORE_W-1:0] : rem_div;
          b_r <= {b_r[B_W-2:0], cy};
        end
        OP_SQRT: begin
          w_r <= cy ? sum[CORE_W-1:0] : rem_sqrt;
          a_r <= {a_r[CORE_W-2:0], cy};
          b_r <= {b_r[B_W-3:0], 2'b00};
        end
        default: begin
          w_r <= sum[CORE_W-1:0];
          a_r <= {a_r[CORE_W-2:0], 1'b0};
          b_r <= {1'b0, b_r[B_W-1:1]};
        end
      endcase
    end
  end

  // result selection
  always_comb begin
    rsp.done = done_r;
    unique case (op_r)
      OP_DIV:  rsp.result = CORE_W'(b_r);
      OP_SQRT: rsp.result = a_r;
      default: rsp.result = w_r;
    endcase
  end

`ifndef SYNTHESIS
  // the sequencer never restarts the core while it is working
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("core started while busy");

  // completion is a single pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("core done held for more than one cycle");
`endif

endmodule

`default_nettype wire

/* hdl/ac_rms_voltage_meter.sv */
// ----------------------------------------------------------------------------
// ac_rms_voltage_meter
// AC rms voltage meter: per loop, an offset window finds the dc level of the
// ADC samples and an rms window sums squared deviations; the mean, square
// root and millivolt scaling of each loop are averaged into one reading.
//
//   channel  direction  handshake              payload
//   in_      sink       in_valid / in_stall    in_sample
//   out_     source     out_valid / out_stall  out_rms_millivolts, out_saturated
//   cfg_     sink       cfg_we                 cfg_index, cfg_data
//
// In the offset window each sample is added to the sum with a single add; in the
// rms window its square is formed by the shift-add multiply in the shared core.
// The offset window end runs one divide; the rms window end runs a divide,
// square root, scaling multiply and add; a reading adds a rounding add and divide.
// Reset is synchronous; there is no clearing pass, a sample may follow at once.
// A waiting result does not block samples; only a new reading stalls for it.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_rms_voltage_meter (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [arms_pkg::ADC_BITS-1:0]       in_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [arms_pkg::MV_W-1:0]                out_rms_millivolts,
  output logic                                     out_saturated,
  input  wire logic                                cfg_we,
  input  wire logic [arms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [arms_pkg::CFG_W-1:0]          cfg_data
);
  import arms_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_ODIV = 4'd2;
  localparam logic [3:0] S_RDIV = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_TOT  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;
  localparam logic [3:0] S_ADIV = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  // configuration
  logic [COUNT_BITS-1:0] spp_r;
  logic [SENS_W-1:0]     sens_r;
  logic [LOOP_W-1:0]     loops_r;
  logic [K_W-1:0]        k_r;

  // measurement state
  logic [3:0]            state_r;
  logic [3:0]            state_nxt;
  logic                  issued_r;
  logic                  phase_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [SUM_W-1:0]      sum_r;
  logic [ADC_BITS-1:0]   offset_r;
  logic [LOOP_W-1:0]     loop_r;
  logic [TOTAL_W-1:0]    total_r;
  logic                  clip_r;
  logic [ADC_BITS-1:0]   s_r;
  logic [ADC_BITS-1:0]   d_r;
  logic [B_W-1:0]        tmp_r;

  // result register
  logic                  out_valid_r;
  logic [MV_W-1:0]       out_mv_r;
  logic                  out_sat_r;

  logic                  in_fire;
  logic                  out_free;
  logic [ADC_BITS-1:0]   diff;
  logic [COUNT_BITS-1:0] len;
  logic [LOOP_W-1:0]     loops_eff;
  logic                  window_end;
  logic [LOOP_W:0]       loop_inc;
  logic                  reading_end;
  logic [RAD_W-1:0]      rad;
  logic                  mv_clip;
  logic [MV_W-1:0]       mv;
  logic [MV_W-1:0]       avg;

  arms_req_t req;
  arms_rsp_t rsp;

  arms_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // handshakes
  assign in_stall           = (state_r != S_IDLE);
  assign in_fire            = in_valid && !in_stall;
  assign out_valid          = out_valid_r;
  assign out_rms_millivolts = out_mv_r;
  assign out_saturated      = out_sat_r;
  assign out_free           = !out_valid_r || !out_stall;

  // window and loop bookkeeping
  assign diff        = (in_sample >= offset_r) ? in_sample - offset_r : offset_r - in_sample;
  assign len         = (spp_r == '0) ? COUNT_BITS'(1) : spp_r;
  assign loops_eff   = (loops_r == '0) ? LOOP_W'(1) : loops_r;
  assign window_end  = (count_r >= len);
  assign loop_inc    = {1'b0, loop_r} + (LOOP_W + 1)'(1);
  assign reading_end = (loop_inc >= {1'b0, loops_eff});

  // scaled loop result and reading average with clipping
  assign rad     = {tmp_r[2*ADC_BITS-1:0], {SQ_FRAC{1'b0}}};
  assign mv_clip = |rsp.result[CORE_W-1:SCALE_SHIFT+MV_W];
  assign mv      = mv_clip ? MV_MAX : rsp.result[SCALE_SHIFT +: MV_W];
  assign avg     = (|tmp_r[B_W-1:MV_W]) ? MV_MAX : tmp_r[MV_W-1:0];

  // core requests per state
  always_comb begin
    req       = '0;
    req.start = !issued_r;
    req.op    = OP_MAC;
    req.steps = STEP_W'(1);
    req.b     = B_W'(1);
    unique case (state_r)
      S_ACC: begin
        req.w = CORE_W'(sum_r);
        if (phase_r) begin
          req.a     = CORE_W'(d_r);
          req.b     = B_W'(d_r);
          req.steps = STEP_W'(ADC_BITS);
        end else begin
          req.a = CORE_W'(s_r);
        end
      end
      S_ODIV, S_RDIV: begin
        req.op    = OP_DIV;
        req.steps = STEP_W'(B_W);
        req.a     = CORE_W'(count_r);
        req.b     = B_W'(sum_r);
      end
      S_SQRT: begin
        req.op    = OP_SQRT;
        req.steps = STEP_W'(ROOT_W);
        req.b     = B_W'(rad) << (B_W - RAD_W);
      end
      S_MUL: begin
        req.steps = STEP_W'(ROOT_W);
        req.w     = CORE_W'(1) << (SCALE_SHIFT - 1);
        req.a     = CORE_W'(k_r);
        req.b     = tmp_r;
      end
      S_TOT: begin
        req.w = CORE_W'(total_r);
        req.a = CORE_W'(tmp_r[MV_W-1:0]);
      end
      S_RND: begin
        req.w = CORE_W'(total_r);
        req.a = CORE_W'(loops_eff >> 1);
      end
      S_ADIV: begin
        req.op    = OP_DIV;
        req.steps = STEP_W'(B_W);
        req.a     = CORE_W'(loops_eff);
        req.b     = tmp_r;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_ACC;
      S_ACC: begin
        if (rsp.done) begin
          if (!window_end) state_nxt = S_IDLE;
          else if (phase_r) state_nxt = S_RDIV;
          else state_nxt = S_ODIV;
        end
      end
      S_ODIV: if (rsp.done) state_nxt = S_IDLE;
      S_RDIV: if (rsp.done) state_nxt = S_SQRT;
      S_SQRT: if (rsp.done) state_nxt = S_MUL;
      S_MUL:  if (rsp.done) state_nxt = S_TOT;
      S_TOT:  if (rsp.done) state_nxt = reading_end ? S_RND : S_IDLE;
      S_RND:  if (rsp.done) state_nxt = S_ADIV;
      S_ADIV: if (rsp.done) state_nxt = S_EMIT;
      S_EMIT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r   <= SPP_RESET;
      sens_r  <= SENS_RESET;
      loops_r <= LOOPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPP:   spp_r   <= cfg_data[COUNT_BITS-1:0];
        REG_SENS:  sens_r  <= cfg_data[SENS_W-1:0];
        REG_LOOPS: loops_r <= cfg_data[LOOP_W-1:0];
        default: ;
      endcase
    end
  end

  // scale factor 3300 * sensitivity
  always_ff @(posedge clk) begin
    k_r <= K_W'(sens_r) * K_W'(SCALE_MV);
  end

  // measurement state and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      phase_r  <= 1'b0;
      count_r  <= '0;
      sum_r    <= '0;
      offset_r <= OFFSET_RESET;
      loop_r   <= '0;
      total_r  <= '0;
      clip_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (rsp.done) begin
        issued_r <= 1'b0;
      end else if (req.start) begin
        issued_r <= 1'b1;
      end

      if (in_fire) begin
        count_r <= count_r + COUNT_BITS'(1);
      end

      unique case (state_r)
        S_ACC: if (rsp.done) sum_r <= rsp.result[SUM_W-1:0];
        S_ODIV: begin
          if (rsp.done) begin
            offset_r <= rsp.result[ADC_BITS-1:0];
            sum_r    <= '0;
            count_r  <= '0;
            phase_r  <= 1'b1;
          end
        end
        S_RDIV: begin
          if (rsp.done) begin
            sum_r   <= '0;
            count_r <= '0;
            phase_r <= 1'b0;
          end
        end
        S_MUL: if (rsp.done) clip_r <= clip_r | mv_clip;
        S_TOT: begin
          if (rsp.done) begin
            total_r <= rsp.result[TOTAL_W-1:0];
            loop_r  <= loop_inc[LOOP_W-1:0];
          end
        end
        S_EMIT: begin
          if (out_free) begin
            total_r <= '0;
            loop_r  <= '0;
            clip_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // sample capture and intermediate results
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_r <= in_sample;
      d_r <= diff;
    end
    unique case (state_r)
      S_RDIV, S_RND, S_ADIV: if (rsp.done) tmp_r <= rsp.result[B_W-1:0];
      S_SQRT: if (rsp.done) tmp_r <= B_W'(rsp.result[ROOT_W-1:0]);
      S_MUL:  if (rsp.done) tmp_r <= B_W'(mv);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_mv_r  <= avg;
      out_sat_r <= clip_r;
    end
  end

`ifndef SYNTHESIS
  // the core only reports completion while an operation state waits for it
  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r != S_IDLE && state_r != S_EMIT && issued_r))
    else $error("core completion outside an operation");

  // the end of the offset window switches to the rms window with a fresh sum
  a_offset_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ODIV && rsp.done) |=> (phase_r && sum_r == '0 && count_r == '0))
    else $error("offset window end did not start rms window");

  // emitting a reading clears the loop totals
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (out_valid_r && loop_r == '0 && total_r == '0))
    else $error("reading emitted without clearing totals");

  // a reading is only emitted at the start of an offset window
  a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (!phase_r && count_r == '0))
    else $error("reading emitted mid-window");
`endif

endmodule

`default_nettype wire
